[rtl/flow_pacing_round_robin_scheduler_macros.svh]
// Assertion helpers used by the checker file.
`ifndef FLOW_PACING_ROUND_ROBIN_SCHEDULER_MACROS_SVH
`define FLOW_PACING_ROUND_ROBIN_SCHEDULER_MACROS_SVH

// Whenever the condition holds, the consequence must hold in the same cycle.
`define FRPR_ASSERT_IMPLY(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("implication failed");

// Whenever the condition holds, the consequence must hold in the next cycle.
`define FRPR_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

[rtl/frpr_pkg.sv]
`default_nettype none
package frpr_pkg;
	localparam int MAX_FLOWS_DEF = 1024;
	localparam int ROW_BITS      = 32;
	localparam int TIME_W        = 32;
	localparam int TAG_W         = 16;
	localparam int BURST_W       = 7;
	localparam logic [BURST_W-1:0] BURST_CAP = 7'd64;

	localparam logic       OP_ADD   = 1'b0;
	localparam logic       OP_VISIT = 1'b1;
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic              is_add;
		logic              cnt_zero;
		logic [TIME_W-1:0] now_time;
		logic [TIME_W-1:0] first_time;
		logic [TIME_W-1:0] interval;
		logic [TIME_W-1:0] packet_count;
		logic [TAG_W-1:0]  flow_tag;
	} item_t;

	typedef struct packed {
		logic [TIME_W-1:0] due;
		logic [TIME_W-1:0] iv;
		logic [TIME_W-1:0] rem;
		logic [TAG_W-1:0]  tag;
	} rec_t;

	typedef struct packed {
		logic             strobe;
		logic [TAG_W-1:0] tag;
		logic             pkt;
		logic             fin;
		logic             last;
		logic [1:0]       status;
	} res_t;
endpackage
`default_nettype wire

[rtl/frpr_ram.sv]
`default_nettype none
module frpr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/frpr_front.sv]
`default_nettype none
module frpr_front import frpr_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              opcode,
	input  wire logic [TIME_W-1:0] now_time,
	input  wire logic [TIME_W-1:0] first_time,
	input  wire logic [TIME_W-1:0] interval,
	input  wire logic [TIME_W-1:0] packet_count,
	input  wire logic [TAG_W-1:0]  flow_tag,
	input  wire logic              clearing,
	input  wire logic              pop,
	output item_t                  item,
	output logic                   item_valid
);
	item_t      buf_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;
	item_t      cls;

	assign busy       = (cnt_q == 2'd2) || clearing;
	assign push       = start && !busy;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = buf_q[rd_q];

	// classify on the way in
	always_comb begin
		cls.is_add       = (opcode == OP_ADD);
		cls.cnt_zero     = (packet_count == '0);
		cls.now_time     = now_time;
		cls.first_time   = first_time;
		cls.interval     = interval;
		cls.packet_count = packet_count;
		cls.flow_tag     = flow_tag;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/frpr_back.sv]
`default_nettype none
module frpr_back import frpr_pkg::*; #(
	parameter int MAX_FLOWS = MAX_FLOWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [BURST_W-1:0] cap,
	input  item_t                   item,
	input  wire logic               item_valid,
	output logic                    pop,
	output logic                    clearing,
	output res_t                    res
);
	localparam int IW   = $clog2(MAX_FLOWS);
	localparam int AFW  = $clog2(MAX_FLOWS + 1);
	localparam int ROWS = (MAX_FLOWS + ROW_BITS - 1) / ROW_BITS;
	localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int BW   = $clog2(ROW_BITS);
	localparam int SW   = RW + BW + 1;

	typedef enum logic [3:0] {
		CLEAR, IDLE, ADD_SRD, ADD_SCHK, ADD_L1, ADD_L2,
		VIS_LD, VIS_LOOP, VIS_WB, VIS_BWR
	} state_t;

	state_t             state_q;
	item_t              item_q;
	logic [RW-1:0]      row_q;
	logic [IW-1:0]      slot_q, ptr_q, nxt_q, prv_q;
	logic [AFW-1:0]     active_q;
	logic [TIME_W-1:0]  due_q, iv_q, rem_q;
	logic [TAG_W-1:0]   tag_q;
	logic [BURST_W-1:0] n_q;
	logic               fin_q;
	res_t               res_q;

	// memory ports
	logic               rec_we, nx_we, pv_we, bm_we;
	logic [IW-1:0]      rec_wa, nx_wa, pv_wa;
	logic [IW-1:0]      nx_wd, pv_wd;
	rec_t               rec_wd, rec_rd;
	logic [IW-1:0]      nx_rd, pv_rd;
	logic [RW-1:0]      bm_wa, bm_ra;
	logic [ROW_BITS-1:0] bm_wd, bm_rd;

	// search and burst datapath
	logic [ROW_BITS-1:0] row_mask, free_bits;
	logic [BW-1:0]       free_bit;
	logic [IW-1:0]       free_slot;
	logic [RW+BW-1:0]    ptr_ext;
	logic [TIME_W:0]     sum;
	logic [TIME_W-1:0]   new_due, new_rem;
	logic                due_lt, new_fin, new_last;

	assign clearing = (state_q == CLEAR);
	assign pop      = (state_q == IDLE) && item_valid;
	assign res      = res_q;
	assign ptr_ext  = (RW + BW)'(ptr_q);

	always_comb begin
		for (int b = 0; b < ROW_BITS; b++) begin
			row_mask[b] = (SW'({row_q, BW'(b)}) < SW'(MAX_FLOWS));
		end
		free_bits = ~bm_rd & row_mask;
		free_bit  = '0;
		for (int b = ROW_BITS - 1; b >= 0; b--) begin
			if (free_bits[b]) free_bit = BW'(b);
		end
		free_slot = IW'({row_q, free_bit});
	end

	always_comb begin
		sum      = {1'b0, due_q} + {1'b0, iv_q};
		new_due  = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
		new_rem  = rem_q - 1'b1;
		new_fin  = (new_rem == '0);
		due_lt   = (due_q < item_q.now_time);
		new_last = new_fin || ((n_q + 1'b1) == cap) || !(new_due < item_q.now_time);
	end

	// memory control, decoded from state
	always_comb begin
		rec_we = 1'b0;  rec_wa = ptr_q;
		rec_wd = '{due: due_q, iv: iv_q, rem: rem_q, tag: tag_q};
		nx_we = 1'b0;  nx_wa = slot_q;  nx_wd = ptr_q;
		pv_we = 1'b0;  pv_wa = slot_q;  pv_wd = slot_q;
		bm_we = 1'b0;  bm_wa = row_q;   bm_wd = '0;
		bm_ra = row_q;
		unique case (state_q)
			CLEAR: begin
				bm_we = 1'b1;
			end
			ADD_SCHK: begin
				if (free_bits != '0) begin
					bm_we  = 1'b1;
					bm_wd  = bm_rd | (ROW_BITS'(1) << free_bit);
					rec_we = 1'b1;
					rec_wa = free_slot;
					rec_wd = '{due: item_q.first_time, iv: item_q.interval,
						rem: item_q.packet_count, tag: item_q.flow_tag};
					if (active_q == '0) begin
						nx_we = 1'b1; nx_wa = free_slot; nx_wd = free_slot;
						pv_we = 1'b1; pv_wa = free_slot; pv_wd = free_slot;
					end
				end
			end
			ADD_L1: begin
				nx_we = 1'b1; nx_wa = pv_rd;  nx_wd = slot_q;
				pv_we = 1'b1; pv_wa = slot_q; pv_wd = pv_rd;
			end
			ADD_L2: begin
				nx_we = 1'b1; nx_wa = slot_q; nx_wd = ptr_q;
				pv_we = 1'b1; pv_wa = ptr_q;  pv_wd = slot_q;
			end
			VIS_WB: begin
				rec_we = 1'b1;
				bm_ra  = ptr_ext[RW+BW-1:BW];
				if (fin_q) begin
					nx_we = 1'b1; nx_wa = prv_q; nx_wd = nxt_q;
					pv_we = 1'b1; pv_wa = nxt_q; pv_wd = prv_q;
				end
			end
			VIS_BWR: begin
				bm_we = 1'b1;
				bm_wa = ptr_ext[RW+BW-1:BW];
				bm_wd = bm_rd & ~(ROW_BITS'(1) << ptr_ext[BW-1:0]);
			end
			default: begin
			end
		endcase
	end

	frpr_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_FLOWS)) u_rec (
		.clk(clk), .we(rec_we), .waddr(rec_wa), .wdata(rec_wd),
		.raddr(ptr_q), .rdata(rec_rd)
	);
	frpr_ram #(.WIDTH(IW), .DEPTH(MAX_FLOWS)) u_next (
		.clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
		.raddr(ptr_q), .rdata(nx_rd)
	);
	frpr_ram #(.WIDTH(IW), .DEPTH(MAX_FLOWS)) u_prev (
		.clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
		.raddr(ptr_q), .rdata(pv_rd)
	);
	frpr_ram #(.WIDTH(ROW_BITS), .DEPTH(ROWS)) u_bitmap (
		.clk(clk), .we(bm_we), .waddr(bm_wa), .wdata(bm_wd),
		.raddr(bm_ra), .rdata(bm_rd)
	);

	always_ff @(posedge clk) begin
		if (pop) item_q <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		res_t res_n;
		if (!arst_n) begin
			state_q  <= CLEAR;
			row_q    <= '0;
			slot_q   <= '0;
			ptr_q    <= '0;
			nxt_q    <= '0;
			prv_q    <= '0;
			active_q <= '0;
			due_q    <= '0;
			iv_q     <= '0;
			rem_q    <= '0;
			tag_q    <= '0;
			n_q      <= '0;
			fin_q    <= 1'b0;
			res_q    <= '0;
		end else begin
			res_n = '0;
			unique case (state_q)
				CLEAR: begin
					if (row_q == RW'(ROWS - 1)) begin
						row_q   <= '0;
						state_q <= IDLE;
					end else begin
						row_q <= row_q + 1'b1;
					end
				end
				IDLE: begin
					if (pop) begin
						row_q <= '0;
						if (item.is_add) begin
							if (item.cnt_zero || active_q == AFW'(MAX_FLOWS)) begin
								res_n = '{strobe: 1'b1, tag: '0, pkt: 1'b0, fin: 1'b0,
									last: 1'b1, status: item.cnt_zero ? ST_OK : ST_FULL};
							end else begin
								state_q <= ADD_SRD;
							end
						end else if (active_q == '0) begin
							res_n = '{strobe: 1'b1, tag: '0, pkt: 1'b0, fin: 1'b0,
								last: 1'b1, status: ST_EMPTY};
						end else begin
							state_q <= VIS_LD;
						end
					end
				end
				ADD_SRD: state_q <= ADD_SCHK;
				ADD_SCHK: begin
					if (free_bits != '0) begin
						slot_q <= free_slot;
						if (active_q == '0) begin
							ptr_q    <= free_slot;
							active_q <= active_q + 1'b1;
							res_n    = '{strobe: 1'b1, tag: '0, pkt: 1'b0, fin: 1'b0,
								last: 1'b1, status: ST_OK};
							state_q  <= IDLE;
						end else begin
							state_q <= ADD_L1;
						end
					end else begin
						// advance to the next bitmap row
						row_q   <= row_q + 1'b1;
						state_q <= ADD_SRD;
					end
				end
				ADD_L1: state_q <= ADD_L2;
				ADD_L2: begin
					active_q <= active_q + 1'b1;
					res_n    = '{strobe: 1'b1, tag: '0, pkt: 1'b0, fin: 1'b0,
						last: 1'b1, status: ST_OK};
					state_q  <= IDLE;
				end
				VIS_LD: begin
					due_q   <= rec_rd.due;
					iv_q    <= rec_rd.iv;
					rem_q   <= rec_rd.rem;
					tag_q   <= rec_rd.tag;
					nxt_q   <= nx_rd;
					prv_q   <= pv_rd;
					n_q     <= '0;
					fin_q   <= 1'b0;
					state_q <= VIS_LOOP;
				end
				VIS_LOOP: begin
					if (!due_lt) begin
						// nothing due on this visit
						res_n   = '{strobe: 1'b1, tag: '0, pkt: 1'b0, fin: 1'b0,
							last: 1'b1, status: ST_OK};
						state_q <= VIS_WB;
					end else begin
						due_q <= new_due;
						rem_q <= new_rem;
						n_q   <= n_q + 1'b1;
						res_n = '{strobe: 1'b1, tag: tag_q, pkt: 1'b1, fin: new_fin,
							last: new_last, status: ST_OK};
						if (new_last) begin
							fin_q   <= new_fin;
							state_q <= VIS_WB;
						end
					end
				end
				VIS_WB: begin
					if (fin_q) begin
						state_q <= VIS_BWR;
					end else begin
						ptr_q   <= nxt_q;
						state_q <= IDLE;
					end
				end
				VIS_BWR: begin
					active_q <= active_q - 1'b1;
					ptr_q    <= (active_q == AFW'(1)) ? '0 : nxt_q;
					state_q  <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
			res_q <= res_n;
		end
	end
endmodule
`default_nettype wire

[rtl/flow_pacing_round_robin_scheduler.sv]
`default_nettype none
// Round-robin flow pacer.
// Command channel: an item transfers at a clock edge with start high and busy
// low. opcode selects add (store a new flow in the lowest free slot and link
// it just ahead of the serve pointer) or visit (serve the flow at the pointer).
// A two-entry queue sits behind the command port, so up to two items may be
// taken while the scheduler core is still working.
// Results: each result is shown for exactly one cycle with result_strobe high;
// the receiver cannot stall, so no back-pressure exists on this side. last
// marks the final result of an item.
// Sequence: an add scans the 32-slot rows of the free-slot bitmap (ADD_SRD and
// ADD_SCHK), then links the flow in (ADD_L1, ADD_L2); a visit loads the record
// (VIS_LD), emits packets (at most max_burst), writes back, unlinks if drained
// (VIS_WB, VIS_BWR). A rejected add or an empty-ring visit answers from IDLE.
// Config: cfg_data (max_burst) transfers on cfg_valid, cfg_ready is always 1.
// A max_burst of 0 acts as 1 and values above 64 act as 64.
// Reset: the ceil(MAX_FLOWS/32) rows of the free-slot bitmap are cleared one
// by one; busy stays high until it is done.
module flow_pacing_round_robin_scheduler import frpr_pkg::*; #(
	parameter int MAX_FLOWS = MAX_FLOWS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic               opcode,
	input  wire logic [TIME_W-1:0]  now_time,
	input  wire logic [TIME_W-1:0]  first_time,
	input  wire logic [TIME_W-1:0]  interval,
	input  wire logic [TIME_W-1:0]  packet_count,
	input  wire logic [TAG_W-1:0]   flow_tag,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [BURST_W-1:0] cfg_data,
	output logic                    result_strobe,
	output logic [TAG_W-1:0]        send_tag,
	output logic                    packet_valid,
	output logic                    flow_finished,
	output logic                    last,
	output logic [1:0]              status
);
	logic [BURST_W-1:0] max_burst_q;
	logic [BURST_W-1:0] cap;
	item_t              item;
	logic               item_valid, pop, clearing;
	res_t               res;

	assign cfg_ready = 1'b1;

	// hold the burst limit; the user writes it only while idle (not enforced here)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_burst_q <= BURST_CAP;
		end else if (cfg_valid && cfg_ready) begin
			max_burst_q <= cfg_data;
		end
	end

	// clamp the limit into 1..64
	always_comb begin
		priority if (max_burst_q == '0) begin
			cap = BURST_W'(1);
		end else if (max_burst_q > BURST_CAP) begin
			cap = BURST_CAP;
		end else begin
			cap = max_burst_q;
		end
	end

	frpr_front u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .now_time(now_time), .first_time(first_time),
		.interval(interval), .packet_count(packet_count), .flow_tag(flow_tag),
		.clearing(clearing), .pop(pop), .item(item), .item_valid(item_valid)
	);

	frpr_back #(.MAX_FLOWS(MAX_FLOWS)) u_back (
		.clk(clk), .arst_n(arst_n), .cap(cap), .item(item),
		.item_valid(item_valid), .pop(pop), .clearing(clearing), .res(res)
	);

	assign result_strobe = res.strobe;
	assign send_tag      = res.tag;
	assign packet_valid  = res.pkt;
	assign flow_finished = res.fin;
	assign last          = res.last;
	assign status        = res.status;
endmodule
`default_nettype wire

[rtl/frpr_checker.sv]
`default_nettype none
`include "flow_pacing_round_robin_scheduler_macros.svh"
module frpr_checker import frpr_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               result_strobe,
	input wire logic [TAG_W-1:0]   send_tag,
	input wire logic               packet_valid,
	input wire logic               flow_finished,
	input wire logic               last,
	input wire logic [1:0]         status
);
	// a result without a packet is always the only one of its item
	`FRPR_ASSERT_IMPLY(a_nopkt_last, clk, arst_n, result_strobe && !packet_valid, last)
	// a drained flow ends the burst
	`FRPR_ASSERT_IMPLY(a_fin_last, clk, arst_n, result_strobe && flow_finished, packet_valid && last)
	// error status never carries a packet
	`FRPR_ASSERT_IMPLY(a_err_nopkt, clk, arst_n, result_strobe && status != ST_OK, !packet_valid && send_tag == '0)
	// a burst result not marked last is followed at once by the next packet
	`FRPR_ASSERT_NEXT(a_burst_cont, clk, arst_n, result_strobe && !last, result_strobe && packet_valid)
endmodule

bind flow_pacing_round_robin_scheduler frpr_checker u_frpr_checker (.*);
`default_nettype wire
